// File: rtl/joystick_to_tank_drive_defines.svh
// ----------------------------------------------------------------------------
// Joystick to tank drive: assertion macros
// Shared assertion forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_TO_TANK_DRIVE_DEFINES_SVH
`define JOYSTICK_TO_TANK_DRIVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JTD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JTD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/jtd_pkg.sv
// ----------------------------------------------------------------------------
// Joystick to tank drive: package
// Widths, constants and the payload record that travels along the cell chains.
// ----------------------------------------------------------------------------
package jtd_pkg;

   localparam int AXIS_FRAC_BITS = 14;
   localparam int ANGLE_STEPS    = 16;

   localparam int AXIS_W  = 16;
   localparam int DRIVE_W = 11;
   localparam int HEAD_W  = 2;
   localparam int DZ_W    = 14;
   localparam int GAIN_W  = 9;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = DZ_W;

   localparam int REQ_DATA_W = ((2 * AXIS_W + 2 + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * DRIVE_W + HEAD_W + 7) / 8) * 8;

   localparam int SUM_W   = AXIS_W + 1;
   localparam int UMAG_W  = AXIS_W;
   localparam int RAD_W   = 2 * AXIS_FRAC_BITS + 4;
   localparam int ROOT_W  = RAD_W / 2 + ANGLE_STEPS;
   localparam int REM_W   = ROOT_W + 2;
   localparam int PROD_W  = ROOT_W + GAIN_W;
   localparam int MQUO_W  = DRIVE_W + ANGLE_STEPS + 1;
   localparam int MHIGH_W = PROD_W - MQUO_W;
   localparam int SPAN_W  = DZ_W + 1;
   localparam int NUM_W   = MQUO_W + UMAG_W;
   localparam int XQUO_W  = DRIVE_W;
   localparam int XHIGH_W = NUM_W - XQUO_W;

   localparam logic signed [AXIS_W-1:0] AXIS_ONE     = AXIS_W'(1) << AXIS_FRAC_BITS;
   localparam logic signed [AXIS_W-1:0] AXIS_NEG_ONE = -AXIS_ONE;
   localparam logic [SPAN_W-1:0]        SPAN_ONE     = SPAN_W'(1) << AXIS_FRAC_BITS;
   localparam logic [MQUO_W-1:0]        MAG_CAP      = MQUO_W'(1) << (DRIVE_W + ANGLE_STEPS);

   localparam logic [DRIVE_W-1:0] DRIVE_POS_MAX = {1'b0, {(DRIVE_W - 1){1'b1}}};
   localparam logic [DRIVE_W-1:0] DRIVE_NEG_MIN = {1'b1, {(DRIVE_W - 1){1'b0}}};

   localparam logic [DZ_W-1:0]   DZ_RESET   = DZ_W'(3277);
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(200);

   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_GAIN = 1'b1;

   localparam logic [HEAD_W-1:0] HEAD_NONE  = 2'd0;
   localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd1;
   localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd2;

   typedef struct packed {
      logic                     valid;
      logic [HEAD_W-1:0]        head;
      logic                     zero;
      logic signed [AXIS_W-1:0] ax;
      logic signed [AXIS_W-1:0] ay;
      logic                     neg_l;
      logic                     neg_r;
      logic [UMAG_W-1:0]        umag_l;
      logic [UMAG_W-1:0]        umag_r;
      logic [RAD_W-1:0]         rad_a;
      logic [RAD_W-1:0]         rad_b;
      logic [REM_W-1:0]         rem_a;
      logic [REM_W-1:0]         rem_b;
      logic [ROOT_W-1:0]        root_a;
      logic [ROOT_W-1:0]        root_b;
      logic [ROOT_W-1:0]        excess;
      logic [PROD_W-1:0]        mprod;
      logic                     msat;
      logic [SPAN_W-1:0]        mpr;
      logic [MQUO_W-1:0]        mnum;
      logic [MQUO_W-1:0]        mquo;
      logic [MQUO_W-1:0]        magq;
      logic [NUM_W-1:0]         xnum_l;
      logic [NUM_W-1:0]         xnum_r;
      logic                     xsat_l;
      logic                     xsat_r;
      logic [ROOT_W-1:0]        xpr_l;
      logic [ROOT_W-1:0]        xpr_r;
      logic [XQUO_W-1:0]        xlow_l;
      logic [XQUO_W-1:0]        xlow_r;
      logic [XQUO_W-1:0]        xquo_l;
      logic [XQUO_W-1:0]        xquo_r;
   } jtd_pipe_type;

endpackage

// File: rtl/joystick_to_tank_drive.sv
// ----------------------------------------------------------------------------
// Joystick to tank drive: top level
// Arcade stick to tank drive mixing with a radial deadzone and head commands.
// ----------------------------------------------------------------------------
// Usage. Each beat on the req channel is one stick sample; each beat on the
// rsp channel is the matching left drive, right drive and head command, in
// order, one result per sample. The csr channel writes the deadzone (index 0)
// and the drive gain (index 1); it is always ready once out of reset. The user
// must see it is written only while no sample is in flight; the block does
// not enforce this. The chain is made of 32 square root cells, 28 magnitude
// divider cells and 11 mixing divider cells, plus the stages between them.
// Throughput: one sample per cycle while req_tready is high; the whole chain
// moves in lock step.
// Reset: synchronous; it empties the chain and the output queue, restores the
// register defaults and clears req_tready and csr_ready.
// Stall: a two-entry output queue parts the sides. While rsp_tready is low
// the chain keeps taking samples until the queue is full, then req_tready
// drops and the chain holds until the receiver takes a beat.
// ----------------------------------------------------------------------------
`include "joystick_to_tank_drive_defines.svh"

module joystick_to_tank_drive (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // stick_x [15:0], stick_y [31:16], left_bumper [32], right_bumper [33], zeros
   input  logic [jtd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // left_drive [10:0], right_drive [21:11], head_command [23:22]
   output logic [jtd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jtd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [jtd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import jtd_pkg::*;

   localparam int REQ_Y_LSB  = AXIS_W;
   localparam int REQ_LB_BIT = 2 * AXIS_W;
   localparam int REQ_RB_BIT = 2 * AXIS_W + 1;

   localparam logic [1:0] Q_EMPTY = 2'd0;
   localparam logic [1:0] Q_ONE   = 2'd1;
   localparam logic [1:0] Q_FULL  = 2'd2;

   function automatic logic [DRIVE_W-1:0] drive_of(input logic zero, input logic neg,
                                                   input logic sat,
                                                   input logic [XQUO_W-1:0] quo);
      logic               over;
      logic [DRIVE_W-1:0] res;
      over = sat || (quo > DRIVE_POS_MAX);
      if (zero) begin
         res = '0;
      end else if (neg) begin
         res = over ? DRIVE_NEG_MIN : DRIVE_W'(~quo) + DRIVE_W'(1);
      end else begin
         res = over ? DRIVE_POS_MAX : quo;
      end
      return res;
   endfunction

   logic [DZ_W-1:0]   dead_zone_ff;
   logic [GAIN_W-1:0] drive_gain_ff;
   logic              csr_ready_ff;
   logic              adv_ff;
   logic              adv_in;
   logic              pipe_adv;
   logic [SPAN_W-1:0] span;
   logic [ROOT_W-1:0] dz_q;

   logic signed [AXIS_W-1:0]   raw_x;
   logic signed [AXIS_W-1:0]   raw_y;
   logic signed [AXIS_W-1:0]   clamp_x;
   logic signed [AXIS_W-1:0]   clamp_y;
   logic signed [SUM_W-1:0]    sum_l;
   logic signed [SUM_W-1:0]    sum_r;
   logic signed [AXIS_W-1:0]   sq_x;
   logic signed [AXIS_W-1:0]   sq_y;
   logic signed [2*AXIS_W-1:0] sqr_x;
   logic signed [2*AXIS_W-1:0] sqr_y;
   logic [RAD_W-1:0]           rad;
   logic [MHIGH_W-1:0]         m_high;
   logic [XHIGH_W-1:0]         x_high_l;
   logic [XHIGH_W-1:0]         x_high_r;

   jtd_pipe_type front_ff, front_in;
   jtd_pipe_type sq_ff, sq_in;
   jtd_pipe_type ex_ff, ex_in;
   jtd_pipe_type pr_ff, pr_in;
   jtd_pipe_type mo_ff, mo_in;
   jtd_pipe_type mg_ff, mg_in;
   jtd_pipe_type nm_ff, nm_in;
   jtd_pipe_type xo_ff, xo_in;
   jtd_pipe_type root_link [ROOT_W+1];
   jtd_pipe_type mdiv_link [MQUO_W+1];
   jtd_pipe_type xdiv_link [XQUO_W+1];
   jtd_pipe_type tail;

   logic [RSP_DATA_W-1:0] word;
   logic [RSP_DATA_W-1:0] head_ff, head_in;
   logic [RSP_DATA_W-1:0] tail_ff, tail_in;
   logic [1:0]            count_ff, count_in;
   logic                  push;
   logic                  pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff  <= DZ_RESET;
         drive_gain_ff <= GAIN_RESET;
         csr_ready_ff  <= 1'b0;
      end else begin
         csr_ready_ff <= 1'b1;
         if (csr_valid && csr_ready_ff) begin
            unique case (csr_index)
               CSR_DEAD_ZONE:  dead_zone_ff  <= csr_data[DZ_W-1:0];
               CSR_DRIVE_GAIN: drive_gain_ff <= csr_data[GAIN_W-1:0];
            endcase
         end
      end
   end

   assign csr_ready  = csr_ready_ff;
   assign pipe_adv   = adv_ff;
   assign req_tready = adv_ff;
   assign span       = SPAN_ONE - SPAN_W'(dead_zone_ff);
   assign dz_q       = ROOT_W'(dead_zone_ff) << ANGLE_STEPS;

   assign raw_x = req_tdata[AXIS_W-1:0];
   assign raw_y = req_tdata[REQ_Y_LSB +: AXIS_W];

   always_comb begin
      front_in       = '0;
      front_in.valid = req_tvalid;
      clamp_x = (raw_x > AXIS_ONE) ? AXIS_ONE : ((raw_x < AXIS_NEG_ONE) ? AXIS_NEG_ONE : raw_x);
      clamp_y = (raw_y > AXIS_ONE) ? AXIS_ONE : ((raw_y < AXIS_NEG_ONE) ? AXIS_NEG_ONE : raw_y);
      sum_l   = SUM_W'(clamp_x) + SUM_W'(clamp_y);
      sum_r   = SUM_W'(clamp_y) - SUM_W'(clamp_x);
      front_in.ax     = clamp_x;
      front_in.ay     = clamp_y;
      front_in.neg_l  = sum_l[SUM_W-1];
      front_in.neg_r  = sum_r[SUM_W-1];
      front_in.umag_l = sum_l[SUM_W-1] ? UMAG_W'(-sum_l) : UMAG_W'(sum_l);
      front_in.umag_r = sum_r[SUM_W-1] ? UMAG_W'(-sum_r) : UMAG_W'(sum_r);
      priority if (req_tdata[REQ_LB_BIT]) begin
         front_in.head = HEAD_LEFT;
      end else if (req_tdata[REQ_RB_BIT]) begin
         front_in.head = HEAD_RIGHT;
      end else begin
         front_in.head = HEAD_NONE;
      end
   end

   assign sq_x  = front_ff.ax;
   assign sq_y  = front_ff.ay;
   assign sqr_x = (2*AXIS_W)'(sq_x) * (2*AXIS_W)'(sq_x);
   assign sqr_y = (2*AXIS_W)'(sq_y) * (2*AXIS_W)'(sq_y);
   assign rad   = RAD_W'($unsigned(sqr_x + sqr_y));

   always_comb begin
      sq_in        = front_ff;
      sq_in.zero   = (rad == '0);
      sq_in.rad_a  = rad;
      sq_in.rad_b  = {rad[RAD_W-2:0], 1'b0};
      sq_in.rem_a  = '0;
      sq_in.rem_b  = '0;
      sq_in.root_a = '0;
      sq_in.root_b = '0;
   end

   assign root_link[0] = sq_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_root
      jtd_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (pipe_adv),
         .up_pipe   (root_link[i]),
         .down_pipe (root_link[i+1])
      );
   end

   always_comb begin
      ex_in        = root_link[ROOT_W];
      ex_in.excess = (root_link[ROOT_W].root_a > dz_q) ? root_link[ROOT_W].root_a - dz_q : '0;
   end

   always_comb begin
      pr_in       = ex_ff;
      pr_in.mprod = PROD_W'(ex_ff.excess) * PROD_W'(drive_gain_ff);
   end

   assign m_high = pr_ff.mprod[PROD_W-1 -: MHIGH_W];

   always_comb begin
      mo_in      = pr_ff;
      mo_in.msat = SPAN_W'(m_high) >= span;
      mo_in.mpr  = SPAN_W'(m_high);
      mo_in.mnum = pr_ff.mprod[MQUO_W-1:0];
      mo_in.mquo = '0;
   end

   assign mdiv_link[0] = mo_ff;

   for (genvar i = 0; i < MQUO_W; i++) begin : g_mdiv
      jtd_mdiv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (pipe_adv),
         .span      (span),
         .up_pipe   (mdiv_link[i]),
         .down_pipe (mdiv_link[i+1])
      );
   end

   always_comb begin
      mg_in      = mdiv_link[MQUO_W];
      mg_in.magq = (mdiv_link[MQUO_W].msat || (mdiv_link[MQUO_W].mquo > MAG_CAP)) ?
                   MAG_CAP : mdiv_link[MQUO_W].mquo;
   end

   always_comb begin
      nm_in        = mg_ff;
      nm_in.xnum_l = NUM_W'(mg_ff.magq) * NUM_W'(mg_ff.umag_l);
      nm_in.xnum_r = NUM_W'(mg_ff.magq) * NUM_W'(mg_ff.umag_r);
   end

   assign x_high_l = nm_ff.xnum_l[NUM_W-1 -: XHIGH_W];
   assign x_high_r = nm_ff.xnum_r[NUM_W-1 -: XHIGH_W];

   always_comb begin
      xo_in        = nm_ff;
      xo_in.xsat_l = x_high_l >= XHIGH_W'(nm_ff.root_b);
      xo_in.xsat_r = x_high_r >= XHIGH_W'(nm_ff.root_b);
      xo_in.xpr_l  = x_high_l[ROOT_W-1:0];
      xo_in.xpr_r  = x_high_r[ROOT_W-1:0];
      xo_in.xlow_l = nm_ff.xnum_l[XQUO_W-1:0];
      xo_in.xlow_r = nm_ff.xnum_r[XQUO_W-1:0];
      xo_in.xquo_l = '0;
      xo_in.xquo_r = '0;
   end

   assign xdiv_link[0] = xo_ff;

   for (genvar i = 0; i < XQUO_W; i++) begin : g_xdiv
      jtd_xdiv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (pipe_adv),
         .up_pipe   (xdiv_link[i]),
         .down_pipe (xdiv_link[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
         sq_ff.valid    <= 1'b0;
         ex_ff.valid    <= 1'b0;
         pr_ff.valid    <= 1'b0;
         mo_ff.valid    <= 1'b0;
         mg_ff.valid    <= 1'b0;
         nm_ff.valid    <= 1'b0;
         xo_ff.valid    <= 1'b0;
      end else if (pipe_adv) begin
         front_ff <= front_in;
         sq_ff    <= sq_in;
         ex_ff    <= ex_in;
         pr_ff    <= pr_in;
         mo_ff    <= mo_in;
         mg_ff    <= mg_in;
         nm_ff    <= nm_in;
         xo_ff    <= xo_in;
      end
   end

   assign tail = xdiv_link[XQUO_W];
   assign word = {tail.head,
                  drive_of(tail.zero, tail.neg_r, tail.xsat_r, tail.xquo_r),
                  drive_of(tail.zero, tail.neg_l, tail.xsat_l, tail.xquo_l)};
   assign push = pipe_adv && tail.valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      unique case (count_ff)
         Q_EMPTY: begin
            if (push) begin
               head_in  = word;
               count_in = Q_ONE;
            end
         end
         Q_ONE: begin
            priority if (push && pop) begin
               head_in = word;
            end else if (push) begin
               tail_in  = word;
               count_in = Q_FULL;
            end else if (pop) begin
               count_in = Q_EMPTY;
            end else begin
               count_in = Q_ONE;
            end
         end
         Q_FULL: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = Q_ONE;
            end
         end
         default: count_in = Q_EMPTY;
      endcase
      adv_in = (count_in != Q_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= Q_EMPTY;
         adv_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         adv_ff   <= adv_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tvalid = (count_ff != Q_EMPTY);
   assign rsp_tdata  = head_ff;

   `JTD_ASSERT_NEXT(a_intake_enters_chain, req_tvalid && req_tready, front_ff.valid,
                    "accepted beat did not enter the chain")
   `JTD_ASSERT_NEXT(a_queue_no_jump, count_ff == Q_EMPTY, count_ff != Q_FULL,
                    "output queue filled by two in one cycle")
   `JTD_ASSERT_NEXT(a_stall_holds_tail, !pipe_adv, $stable(tail),
                    "chain end changed while the chain was held")
   `JTD_ASSERT_NOW(a_root_order, root_link[ROOT_W].valid,
                   root_link[ROOT_W].root_b >= root_link[ROOT_W].root_a,
                   "doubled radius root below plain radius root")

endmodule

// File: rtl/jtd_root_cell.sv
// ----------------------------------------------------------------------------
// Joystick to tank drive: square root cell
// One digit of the two stick radius roots, the plain and the doubled radicand.
// ----------------------------------------------------------------------------
module jtd_root_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  jtd_pkg::jtd_pipe_type up_pipe,
   output jtd_pkg::jtd_pipe_type down_pipe
);
   import jtd_pkg::*;

   jtd_pipe_type     stage_ff;
   jtd_pipe_type     stage_in;
   logic [REM_W+1:0] part_a;
   logic [REM_W+1:0] part_b;
   logic [REM_W+1:0] trial_a;
   logic [REM_W+1:0] trial_b;
   logic             take_a;
   logic             take_b;

   always_comb begin
      stage_in = up_pipe;
      part_a   = {up_pipe.rem_a, up_pipe.rad_a[RAD_W-1 -: 2]};
      part_b   = {up_pipe.rem_b, up_pipe.rad_b[RAD_W-1 -: 2]};
      trial_a  = {2'b00, up_pipe.root_a, 2'b01};
      trial_b  = {2'b00, up_pipe.root_b, 2'b01};
      take_a   = part_a >= trial_a;
      take_b   = part_b >= trial_b;
      stage_in.rem_a  = take_a ? REM_W'(part_a - trial_a) : REM_W'(part_a);
      stage_in.rem_b  = take_b ? REM_W'(part_b - trial_b) : REM_W'(part_b);
      stage_in.root_a = {up_pipe.root_a[ROOT_W-2:0], take_a};
      stage_in.root_b = {up_pipe.root_b[ROOT_W-2:0], take_b};
      stage_in.rad_a  = {up_pipe.rad_a[RAD_W-3:0], 2'b00};
      stage_in.rad_b  = {up_pipe.rad_b[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign down_pipe = stage_ff;

endmodule

// File: rtl/jtd_mdiv_cell.sv
// ----------------------------------------------------------------------------
// Joystick to tank drive: magnitude divider cell
// One quotient bit of the scaled excess radius divided by the deadzone span.
// ----------------------------------------------------------------------------
module jtd_mdiv_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [jtd_pkg::SPAN_W-1:0]    span,
   input  jtd_pkg::jtd_pipe_type         up_pipe,
   output jtd_pkg::jtd_pipe_type         down_pipe
);
   import jtd_pkg::*;

   jtd_pipe_type    stage_ff;
   jtd_pipe_type    stage_in;
   logic [SPAN_W:0] part;
   logic [SPAN_W:0] span_ext;
   logic            take;

   always_comb begin
      stage_in = up_pipe;
      part     = {up_pipe.mpr, up_pipe.mnum[MQUO_W-1]};
      span_ext = {1'b0, span};
      take     = part >= span_ext;
      stage_in.mpr  = take ? SPAN_W'(part - span_ext) : SPAN_W'(part);
      stage_in.mnum = {up_pipe.mnum[MQUO_W-2:0], 1'b0};
      stage_in.mquo = {up_pipe.mquo[MQUO_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign down_pipe = stage_ff;

endmodule

// File: rtl/jtd_xdiv_cell.sv
// ----------------------------------------------------------------------------
// Joystick to tank drive: mixing divider cell
// One quotient bit of each motor drive divided by the doubled radicand root.
// ----------------------------------------------------------------------------
module jtd_xdiv_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  jtd_pkg::jtd_pipe_type up_pipe,
   output jtd_pkg::jtd_pipe_type down_pipe
);
   import jtd_pkg::*;

   jtd_pipe_type    stage_ff;
   jtd_pipe_type    stage_in;
   logic [ROOT_W:0] part_l;
   logic [ROOT_W:0] part_r;
   logic [ROOT_W:0] den_ext;
   logic            take_l;
   logic            take_r;

   always_comb begin
      stage_in = up_pipe;
      den_ext  = {1'b0, up_pipe.root_b};
      part_l   = {up_pipe.xpr_l, up_pipe.xlow_l[XQUO_W-1]};
      part_r   = {up_pipe.xpr_r, up_pipe.xlow_r[XQUO_W-1]};
      take_l   = part_l >= den_ext;
      take_r   = part_r >= den_ext;
      stage_in.xpr_l  = take_l ? ROOT_W'(part_l - den_ext) : ROOT_W'(part_l);
      stage_in.xpr_r  = take_r ? ROOT_W'(part_r - den_ext) : ROOT_W'(part_r);
      stage_in.xlow_l = {up_pipe.xlow_l[XQUO_W-2:0], 1'b0};
      stage_in.xlow_r = {up_pipe.xlow_r[XQUO_W-2:0], 1'b0};
      stage_in.xquo_l = {up_pipe.xquo_l[XQUO_W-2:0], take_l};
      stage_in.xquo_r = {up_pipe.xquo_r[XQUO_W-2:0], take_r};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign down_pipe = stage_ff;

endmodule

// File: sim/tb_joystick_to_tank_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick to tank drive: testbench
// Sends stick samples through the req stream under several deadzone and gain
// settings and with random idle and stall patterns. Each sample's drive beat
// is predicted in fixed point and compared field by field with the rsp stream.
// ----------------------------------------------------------------------------
module tb_joystick_to_tank_drive;
   import jtd_pkg::*;

   typedef longint unsigned u64_t;

   typedef struct {
      logic signed [DRIVE_W-1:0] left;
      logic signed [DRIVE_W-1:0] right;
      logic [HEAD_W-1:0]         head;
   } drive_beat_t;

   localparam longint FULL_SCALE = longint'(1) << AXIS_FRAC_BITS;
   localparam u64_t   MAG_LIMIT  = u64_t'(2048) << ANGLE_STEPS;
   localparam longint DRIVE_HI   = (longint'(1) << (DRIVE_W - 1)) - 1;
   localparam longint DRIVE_LO   = -(longint'(1) << (DRIVE_W - 1));
   localparam int     LONG_HOLD  = 400;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_DEAD_ZONE;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   logic [DZ_W-1:0]   dz_setting   = DZ_RESET;
   logic [GAIN_W-1:0] gain_setting = GAIN_RESET;
   drive_beat_t       expected_drives[$];

   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int stall_left     = 0;
   int samples_sent   = 0;
   int beats_checked  = 0;
   int settings_used  = 1;
   int mismatch_count = 0;

   int unsigned sweep_dz[6]   = '{0, 16383, 0, 8192, 16000, DZ_RESET};
   int unsigned sweep_gain[6] = '{511, 511, 0, 300, 1, GAIN_RESET};
   int          pace_idle[4]  = '{0, 46, 0, 13};
   int          pace_stall[4] = '{0, 0, 46, 13};

   joystick_to_tank_drive DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_axis(logic signed [AXIS_W-1:0] raw);
      longint v;
      v = raw;
      if (v > FULL_SCALE) v = FULL_SCALE;
      if (v < -FULL_SCALE) v = -FULL_SCALE;
      return v;
   endfunction

   // floor(sqrt(sum) * 2^ANGLE_STEPS), two bits at a time.
   function automatic u64_t scaled_root(u64_t sum);
      u64_t val, rem, root, trial;
      val  = sum << (2 * ANGLE_STEPS);
      rem  = 0;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         rem   = (rem << 2) | ((val >> (2 * i)) & u64_t'(3));
         trial = (root << 2) | u64_t'(1);
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | u64_t'(1);
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic signed [DRIVE_W-1:0] mix_drive(u64_t mag_q, longint u, u64_t den);
      u64_t   q;
      longint d;
      q = mag_q * u64_t'((u < 0) ? -u : u) / den;
      if (q > 2048) q = 2048;
      d = (u < 0) ? -longint'(q) : longint'(q);
      if (d > DRIVE_HI) d = DRIVE_HI;
      if (d < DRIVE_LO) d = DRIVE_LO;
      return DRIVE_W'(d);
   endfunction

   function automatic drive_beat_t predict_drive(logic signed [AXIS_W-1:0] raw_x,
                                                 logic signed [AXIS_W-1:0] raw_y,
                                                 logic lb, logic rb);
      longint      x, y;
      u64_t        sum_sq, r_q, big_q, dz_q, excess, mag_q;
      drive_beat_t res;
      x         = clamp_axis(raw_x);
      y         = clamp_axis(raw_y);
      sum_sq    = u64_t'(x * x + y * y);
      res.left  = '0;
      res.right = '0;
      if (sum_sq != 0 && longint'(dz_setting) < FULL_SCALE) begin
         r_q    = scaled_root(sum_sq);
         big_q  = scaled_root(2 * sum_sq);
         dz_q   = u64_t'(dz_setting) << ANGLE_STEPS;
         excess = (r_q > dz_q) ? r_q - dz_q : u64_t'(0);
         mag_q  = excess * u64_t'(gain_setting) / u64_t'(FULL_SCALE - longint'(dz_setting));
         if (mag_q > MAG_LIMIT) mag_q = MAG_LIMIT;
         res.left  = mix_drive(mag_q, x + y, big_q);
         res.right = mix_drive(mag_q, y - x, big_q);
      end
      res.head = lb ? HEAD_LEFT : (rb ? HEAD_RIGHT : HEAD_NONE);
      return res;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      drive_beat_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (expected_drives.size() == 0) begin
            report_mismatch($sformatf("drive beat %h with no sample outstanding", rsp_tdata));
         end else begin
            want = expected_drives.pop_front();
            if (rsp_tdata[DRIVE_W-1:0] !== want.left) begin
               report_mismatch($sformatf("beat %0d left drive %0d, expected %0d", beats_checked,
                  $signed(rsp_tdata[DRIVE_W-1:0]), want.left));
            end
            if (rsp_tdata[2*DRIVE_W-1:DRIVE_W] !== want.right) begin
               report_mismatch($sformatf("beat %0d right drive %0d, expected %0d", beats_checked,
                  $signed(rsp_tdata[2*DRIVE_W-1:DRIVE_W]), want.right));
            end
            if (rsp_tdata[2*DRIVE_W+HEAD_W-1:2*DRIVE_W] !== want.head) begin
               report_mismatch($sformatf("beat %0d head command %0d, expected %0d", beats_checked,
                  rsp_tdata[2*DRIVE_W+HEAD_W-1:2*DRIVE_W], want.head));
            end
         end
      end
   end

   task automatic set_pacing(int idle_pct, int stall_pct);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic send_sample(int x, int y, bit lb, bit rb);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({rb, lb, AXIS_W'(y), AXIS_W'(x)});
      do @(posedge clock); while (!req_tready);
      expected_drives.push_back(predict_drive(AXIS_W'(x), AXIS_W'(y), lb, rb));
      samples_sent++;
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
   endtask

   task automatic send_random_sample();
      int x, y, reach;
      reach = int'(dz_setting) + 512;
      case ($urandom_range(9))
         0: begin
            x = int'($urandom_range(16'hFFFF));
            y = int'($urandom_range(16'hFFFF));
         end
         1: begin
            x = int'($urandom_range(2 * reach)) - reach;
            y = int'($urandom_range(2 * reach)) - reach;
         end
         2: begin
            x = (int'($urandom_range(2)) - 1) * int'(FULL_SCALE);
            y = (int'($urandom_range(2)) - 1) * int'(FULL_SCALE);
         end
         default: begin
            x = int'($urandom_range(2 * FULL_SCALE)) - int'(FULL_SCALE);
            y = int'($urandom_range(2 * FULL_SCALE)) - int'(FULL_SCALE);
         end
      endcase
      send_sample(x, y, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic finish_batch();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_drives.size() != 0);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DEAD_ZONE) begin
         dz_setting = DZ_W'(value);
      end else begin
         gain_setting = GAIN_W'(value);
      end
   endtask

   task automatic apply_setting(int unsigned dz, int unsigned gain);
      finish_batch();
      write_register(CSR_DEAD_ZONE, dz);
      write_register(CSR_DRIVE_GAIN, gain);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic test_directed_samples();
      set_pacing(0, 0);
      send_sample(0, 0, 0, 0);
      send_sample(16384, 0, 0, 0);
      send_sample(-16384, 0, 1, 0);
      send_sample(0, 16384, 0, 1);
      send_sample(0, -16384, 1, 1);
      send_sample(16384, 16384, 0, 0);
      send_sample(-16384, -16384, 0, 0);
      send_sample(16384, -16384, 0, 0);
      send_sample(-16384, 16384, 0, 0);
      send_sample(32767, -32768, 1, 0);
      send_sample(-32768, 32767, 0, 1);
      send_sample(20000, 100, 0, 0);
      send_sample(-100, -30000, 0, 0);
      send_sample(100, 100, 0, 0);
      send_sample(3277, 0, 0, 0);
      send_sample(3278, 0, 0, 0);
      send_sample(1, 0, 0, 0);
      send_sample(-1, -1, 0, 0);
      send_sample(11585, 11585, 1, 1);
   endtask

   task automatic test_register_sweep();
      for (int s = 0; s < 6; s++) begin
         apply_setting(sweep_dz[s], sweep_gain[s]);
         for (int p = 0; p < 4; p++) begin
            set_pacing(pace_idle[p], pace_stall[p]);
            repeat (50) send_random_sample();
         end
      end
   endtask

   task automatic test_backpressure();
      set_pacing(0, 0);
      stall_left = LONG_HOLD;
      repeat (120) send_random_sample();
      finish_batch();
      set_pacing(13, 13);
      repeat (20) send_random_sample();
   endtask

   task automatic test_random_settings();
      int unsigned dz;
      int          p;
      for (int s = 0; s < 8; s++) begin
         case ($urandom_range(3))
            0: dz = $urandom_range(16383);
            1: dz = $urandom_range(4000);
            2: dz = 16383 - $urandom_range(200);
            default: dz = DZ_RESET;
         endcase
         apply_setting(dz, $urandom_range(511));
         p = $urandom_range(3);
         set_pacing(pace_idle[p], pace_stall[p]);
         repeat (70) send_random_sample();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_samples();
      test_register_sweep();
      test_backpressure();
      test_random_settings();
      finish_batch();
      repeat (120) @(posedge clock);
      if (expected_drives.size() != 0) begin
         report_mismatch($sformatf("%0d drive beats never arrived", expected_drives.size()));
      end
      $display("Run covered %0d stick samples and %0d drive beats over %0d register settings,",
               samples_sent, beats_checked, settings_used);
      $display("with four pacing mixes and a %0d-cycle receiver hold-off.", LONG_HOLD);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out waiting for the drive beats.");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: joystick_to_tank_drive.f
+incdir+rtl
rtl/jtd_pkg.sv
rtl/jtd_root_cell.sv
rtl/jtd_mdiv_cell.sv
rtl/jtd_xdiv_cell.sv
rtl/joystick_to_tank_drive.sv
sim/tb_joystick_to_tank_drive.sv
